// ===== design/best_fit_heap_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit heap allocator
// Immediate-implication and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BFHA_AP_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BFHA_AP_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg
// Word types, opcodes, status codes and heap layout constants.
// ----------------------------------------------------------------------------
package bfha_pkg;

	typedef logic [31:0] word_t;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERO    = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	localparam word_t SIZE_MASK   = ~32'h7;
	localparam word_t ALLOC_BIT   = 32'h1;
	localparam word_t DSIZE       = 32'd8;
	localparam word_t MIN_BLOCK   = 32'd16;
	localparam word_t ALIGN_ADD   = 32'd15;
	localparam word_t LINK_OFF    = 32'd4;
	localparam word_t PRO_HDR_OFF = 32'd4;
	localparam word_t PRO_FTR_OFF = 32'd16;
	localparam word_t EPI_OFF     = 32'd20;
	localparam word_t HEAP_BASE   = 32'd24;
	localparam word_t PRO_TAG     = 32'd17;
	localparam word_t EPI_TAG     = 32'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [16:0] request_bytes;
		logic [15:0] block_ptr;
	} req_t;

	typedef struct packed {
		logic [15:0] result_ptr;
		logic [1:0]  status;
		logic        moved;
		logic [16:0] copy_bytes;
	} rsp_t;

	function automatic word_t size_of(input word_t w);
		return w & SIZE_MASK;
	endfunction

endpackage

// ===== design/best_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Best-fit allocator with boundary tags and a LIFO explicit free list.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one word per request:
//   op (allocate, free, resize), request_bytes and block_ptr. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one word per request with
//   result_ptr, status, moved and copy_bytes; the client does any copy.
// Sequencing:
//   One request at a time; req_stall stays high while a request is in work.
//   Each step makes at most one access of the single heap RAM port; steps
//   form the best-fit walk, unlinks, pushes, heap growth and coalesces.
//   A free of null or the unused code goes from dispatch straight to its
//   response; an alloc or free runs the walk, unlinks and pushes it needs.
// Reset:
//   arst_n clears control state and starts a clearing pass that zeroes the
//   HEAP_BYTES/4 RAM words one per cycle, then builds prologue, epilogue
//   and the first CHUNK_BYTES free block. No request is taken until then.
// Stall:
//   The response sits in an output register; while rsp_stall holds it, a new
//   request can still be accepted and run, and its response waits in the
//   sequencer until the register is free.
// ----------------------------------------------------------------------------
`include "best_fit_heap_allocator_core_assert.svh"

module best_fit_heap_allocator_core
	import bfha_pkg::*;
#(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int WORDS = HEAP_BYTES / 4;
	localparam int AW    = $clog2(WORDS);

	logic          seq_ready;
	logic          res_valid;
	logic          res_taken;
	rsp_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	word_t         mem_wdata;
	word_t         mem_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	assign req_stall = !seq_ready;

	// hand the finished word to the output register once it is free
	assign res_taken = res_valid && (!rsp_valid_q || !rsp_stall);

	bfha_seq #(
		.HEAP_BYTES  (HEAP_BYTES),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_accept (req_valid && seq_ready),
		.req        (req),
		.ready      (seq_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_taken  (res_taken),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	// heap word store: headers, footers and free-list links
	bfha_ram #(
		.WIDTH (32),
		.DEPTH (WORDS)
	) u_heap (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_taken) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BFHA_AP_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
		"request accepted but block still ready")
	`BFHA_AP_NOW(a_no_overwrite, res_taken, !(rsp_valid && rsp_stall),
		"response register overwritten while stalled")
	`BFHA_AP_NOW(a_status_code, rsp_valid,
		rsp.status == ST_OK || rsp.status == ST_ZERO || rsp.status == ST_NOSPACE,
		"illegal status code")
	`BFHA_AP_NOW(a_moved_ok, rsp_valid && rsp.moved, rsp.status == ST_OK,
		"moved flag on a failed request")

endmodule

// ===== design/bfha_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_ram
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== design/bfha_seq.sv =====
// ----------------------------------------------------------------------------
// bfha_seq
// Allocator sequencer: walks the heap memory with at most one access per cycle.
// ----------------------------------------------------------------------------
module bfha_seq
	import bfha_pkg::*;
#(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_accept,
	input  req_t                              req,
	output logic                              ready,
	output logic                              res_valid,
	output rsp_t                              res,
	input  logic                              res_taken,
	output logic                              mem_we,
	output logic [$clog2(HEAP_BYTES/4)-1:0]   mem_addr,
	output word_t                             mem_wdata,
	input  word_t                             mem_rdata
);

	localparam int WORDS      = HEAP_BYTES / 4;
	localparam int AW         = $clog2(WORDS);
	localparam int WALK_LIMIT = HEAP_BYTES / 16 + 1;
	localparam int NW         = $clog2(WALK_LIMIT + 1);
	localparam word_t HEAP_LIM = word_t'(HEAP_BYTES);
	localparam word_t CHUNK    = word_t'(CHUNK_BYTES);

	typedef enum logic [5:0] {
		S_CLR, S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DISP,
		S_ALLOC, S_BF0, S_BF1, S_BF2, S_BFEND,
		S_GROW0, S_GROW1, S_GROW2, S_GROW3,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_MW0, S_MW1, S_MRET,
		S_UL0, S_UL1, S_UL2, S_UL3, S_UL4,
		S_PU0, S_PU1, S_PU2,
		S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5, S_PL6, S_PL7, S_PL8, S_ADONE,
		S_FR0, S_FR1, S_FR2, S_FR3,
		S_RS0, S_RS1, S_RS2, S_RS3, S_RS4, S_RS5, S_RS6, S_RS7,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MR_PLACE,
		MR_FREE,
		MR_INIT
	} mret_t;

	state_t           state_q, lret_q;
	mret_t            mret_q;
	logic [AW-1:0]    clr_q;
	logic [1:0]       op_q;
	logic [16:0]      bytes_q;
	word_t            ptr_q;
	logic [15:0]      res_q;
	logic [1:0]       st_q;
	logic             moved_q;
	logic [16:0]      copy_q;
	logic             mv_q;
	word_t            asize_q, w_q, best_q, bsz_q, g_q, top_q, head_q;
	logic [NW-1:0]    n_q;
	word_t            bp_q, s_q, pv_q, nx_q, pvsz_q, nxsz_q;
	logic             pa_q, na_q;
	word_t            un_q, unn_q, unp_q, ps_q, pl_q, c_q, old_q;

	word_t            rd_sz, bytes32, grow_sz, old_cp;

	function automatic logic [AW-1:0] wa(input word_t off);
		return off[AW+1:2];
	endfunction

	assign rd_sz   = size_of(mem_rdata);
	assign bytes32 = {15'b0, bytes_q};
	assign grow_sz = {g_q[31:2], 2'b00} + (g_q[2] ? 32'd4 : 32'd0);
	assign old_cp  = (old_q >= DSIZE) ? old_q - DSIZE : 32'd0;

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{result_ptr: res_q, status: st_q, moved: moved_q, copy_bytes: copy_q};

	// memory port
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_INIT0: begin
				mem_we = 1'b1; mem_addr = wa(PRO_HDR_OFF); mem_wdata = PRO_TAG;
			end
			S_INIT1: begin
				mem_we = 1'b1; mem_addr = wa(PRO_FTR_OFF); mem_wdata = PRO_TAG;
			end
			S_INIT2: begin
				mem_we = 1'b1; mem_addr = wa(EPI_OFF); mem_wdata = EPI_TAG;
			end
			S_BF0: mem_addr = wa(w_q - LINK_OFF);
			S_BF1: mem_addr = wa(w_q);
			S_GROW1: begin
				mem_we = 1'b1; mem_addr = wa(bp_q - LINK_OFF); mem_wdata = s_q;
			end
			S_GROW2: begin
				mem_we = 1'b1; mem_addr = wa(bp_q + s_q - DSIZE); mem_wdata = s_q;
			end
			S_GROW3: begin
				mem_we = 1'b1; mem_addr = wa(bp_q + s_q - LINK_OFF); mem_wdata = EPI_TAG;
			end
			S_M0: mem_addr = wa(bp_q - DSIZE);
			S_M1: mem_addr = wa(bp_q - LINK_OFF);
			S_M2: mem_addr = wa(pv_q - LINK_OFF);
			S_M3: mem_addr = wa(pv_q + rd_sz - DSIZE);
			S_M4: mem_addr = wa(nx_q - LINK_OFF);
			S_M5: mem_addr = wa(nx_q + rd_sz - DSIZE);
			S_MW0: begin
				mem_we = 1'b1; mem_addr = wa(bp_q - LINK_OFF); mem_wdata = s_q;
			end
			S_MW1: begin
				mem_we = 1'b1; mem_addr = wa(bp_q + s_q - DSIZE); mem_wdata = s_q;
			end
			S_UL0: mem_addr = wa(un_q);
			S_UL1: mem_addr = wa(un_q + LINK_OFF);
			S_UL3: begin
				mem_we = (unp_q != '0); mem_addr = wa(unp_q); mem_wdata = unn_q;
			end
			S_UL4: begin
				mem_we = (unn_q != '0); mem_addr = wa(unn_q + LINK_OFF); mem_wdata = unp_q;
			end
			S_PU0: begin
				mem_we = 1'b1; mem_addr = wa(ps_q); mem_wdata = head_q;
			end
			S_PU1: begin
				mem_we = 1'b1; mem_addr = wa(ps_q + LINK_OFF);
			end
			S_PU2: begin
				mem_we = (head_q != '0); mem_addr = wa(head_q + LINK_OFF); mem_wdata = ps_q;
			end
			S_PL0: mem_addr = wa(pl_q - LINK_OFF);
			S_PL3: begin
				mem_we = 1'b1; mem_addr = wa(pl_q - LINK_OFF); mem_wdata = asize_q | ALLOC_BIT;
			end
			S_PL4: begin
				mem_we = 1'b1; mem_addr = wa(pl_q + asize_q - DSIZE);
				mem_wdata = asize_q | ALLOC_BIT;
			end
			S_PL5: begin
				mem_we = 1'b1; mem_addr = wa(pl_q + asize_q - LINK_OFF);
				mem_wdata = c_q - asize_q;
			end
			S_PL6: begin
				mem_we = 1'b1; mem_addr = wa(pl_q + c_q - DSIZE); mem_wdata = c_q - asize_q;
			end
			S_PL7: begin
				mem_we = 1'b1; mem_addr = wa(pl_q - LINK_OFF); mem_wdata = c_q | ALLOC_BIT;
			end
			S_PL8: begin
				mem_we = 1'b1; mem_addr = wa(pl_q + c_q - DSIZE); mem_wdata = c_q | ALLOC_BIT;
			end
			S_FR0: mem_addr = wa(ptr_q - LINK_OFF);
			S_FR2: begin
				mem_we = 1'b1; mem_addr = wa(ptr_q - LINK_OFF); mem_wdata = s_q;
			end
			S_FR3: begin
				mem_we = 1'b1; mem_addr = wa(ptr_q + s_q - DSIZE); mem_wdata = s_q;
			end
			S_RS0: mem_addr = wa(ptr_q - LINK_OFF);
			S_RS2: mem_addr = wa(nx_q - LINK_OFF);
			S_RS4: mem_addr = wa(nx_q - LINK_OFF);
			S_RS6: begin
				mem_we = 1'b1; mem_addr = wa(ptr_q - LINK_OFF); mem_wdata = s_q | ALLOC_BIT;
			end
			S_RS7: begin
				mem_we = 1'b1; mem_addr = wa(ptr_q + s_q - DSIZE); mem_wdata = s_q | ALLOC_BIT;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			lret_q  <= S_IDLE;
			mret_q  <= MR_INIT;
			clr_q   <= '0;
			op_q    <= '0;
			bytes_q <= '0;
			ptr_q   <= '0;
			res_q   <= '0;
			st_q    <= ST_OK;
			moved_q <= 1'b0;
			copy_q  <= '0;
			mv_q    <= 1'b0;
			asize_q <= '0;
			w_q     <= '0;
			best_q  <= '0;
			bsz_q   <= '0;
			g_q     <= '0;
			top_q   <= HEAP_BASE;
			head_q  <= '0;
			n_q     <= '0;
			bp_q    <= '0;
			s_q     <= '0;
			pv_q    <= '0;
			nx_q    <= '0;
			pvsz_q  <= '0;
			nxsz_q  <= '0;
			pa_q    <= 1'b0;
			na_q    <= 1'b0;
			un_q    <= '0;
			unn_q   <= '0;
			unp_q   <= '0;
			ps_q    <= '0;
			pl_q    <= '0;
			c_q     <= '0;
			old_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(WORDS - 1)) state_q <= S_INIT0;
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_INIT2;
				S_INIT2: begin
					g_q     <= CHUNK;
					mret_q  <= MR_INIT;
					state_q <= S_GROW0;
				end
				S_IDLE: begin
					if (req_accept) begin
						op_q    <= req.op;
						bytes_q <= req.request_bytes;
						ptr_q   <= {16'b0, req.block_ptr};
						res_q   <= '0;
						st_q    <= ST_OK;
						moved_q <= 1'b0;
						copy_q  <= '0;
						mv_q    <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (op_q)
						OP_ALLOC: state_q <= S_ALLOC;
						OP_FREE:  state_q <= (ptr_q != '0) ? S_FR0 : S_DONE;
						OP_RESIZE: begin
							if (ptr_q == '0) begin
								state_q <= S_ALLOC;
							end else if (bytes_q == '0) begin
								st_q    <= ST_ZERO;
								state_q <= S_FR0;
							end else begin
								state_q <= S_RS0;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_ALLOC: begin
					if (bytes_q == '0) begin
						st_q    <= ST_ZERO;
						state_q <= S_DONE;
					end else begin
						asize_q <= (bytes32 <= DSIZE) ? MIN_BLOCK
							: ((bytes32 + ALIGN_ADD) & SIZE_MASK);
						w_q     <= head_q;
						n_q     <= '0;
						best_q  <= '0;
						bsz_q   <= '1;
						state_q <= S_BF0;
					end
				end
				S_BF0: begin
					if (w_q == '0 || n_q >= NW'(WALK_LIMIT)) state_q <= S_BFEND;
					else state_q <= S_BF1;
				end
				S_BF1: begin
					state_q <= S_BF2;
					if (!mem_rdata[0] && rd_sz >= asize_q) begin
						if (rd_sz == asize_q) begin
							pl_q    <= w_q;
							state_q <= S_PL0;
						end else if (rd_sz < bsz_q) begin
							best_q <= w_q;
							bsz_q  <= rd_sz;
						end
					end
				end
				S_BF2: begin
					w_q     <= mem_rdata;
					n_q     <= n_q + 1'b1;
					state_q <= S_BF0;
				end
				S_BFEND: begin
					if (best_q != '0) begin
						pl_q    <= best_q;
						state_q <= S_PL0;
					end else begin
						g_q     <= (asize_q > CHUNK) ? asize_q : CHUNK;
						mret_q  <= MR_PLACE;
						state_q <= S_GROW0;
					end
				end
				S_GROW0: begin
					if (top_q > HEAP_LIM || grow_sz > HEAP_LIM - top_q) begin
						if (mret_q == MR_INIT) begin
							state_q <= S_IDLE;
						end else begin
							st_q    <= ST_NOSPACE;
							res_q   <= '0;
							state_q <= S_DONE;
						end
					end else begin
						bp_q    <= top_q;
						s_q     <= grow_sz;
						top_q   <= top_q + grow_sz;
						state_q <= S_GROW1;
					end
				end
				S_GROW1: state_q <= S_GROW2;
				S_GROW2: state_q <= S_GROW3;
				S_GROW3: state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: begin
					pv_q    <= bp_q - rd_sz;
					state_q <= S_M2;
				end
				S_M2: begin
					s_q     <= rd_sz;
					nx_q    <= bp_q + rd_sz;
					state_q <= S_M3;
				end
				S_M3: begin
					pvsz_q  <= rd_sz;
					state_q <= S_M4;
				end
				S_M4: begin
					pa_q    <= mem_rdata[0];
					state_q <= S_M5;
				end
				S_M5: begin
					na_q    <= mem_rdata[0];
					nxsz_q  <= rd_sz;
					state_q <= S_M6;
				end
				S_M6: begin
					if (!pa_q && !na_q) begin
						s_q     <= s_q + pvsz_q + rd_sz;
						bp_q    <= pv_q;
						un_q    <= pv_q;
						lret_q  <= S_M7;
						state_q <= S_UL0;
					end else if (!pa_q) begin
						s_q     <= s_q + pvsz_q;
						bp_q    <= pv_q;
						un_q    <= pv_q;
						lret_q  <= S_MW0;
						state_q <= S_UL0;
					end else if (!na_q) begin
						s_q     <= s_q + nxsz_q;
						un_q    <= nx_q;
						lret_q  <= S_MW0;
						state_q <= S_UL0;
					end else begin
						state_q <= S_MW0;
					end
				end
				S_M7: begin
					un_q    <= nx_q;
					lret_q  <= S_MW0;
					state_q <= S_UL0;
				end
				S_MW0: state_q <= S_MW1;
				S_MW1: begin
					ps_q    <= bp_q;
					lret_q  <= S_MRET;
					state_q <= S_PU0;
				end
				S_MRET: begin
					unique case (mret_q)
						MR_PLACE: begin
							pl_q    <= bp_q;
							state_q <= S_PL0;
						end
						MR_FREE: state_q <= S_DONE;
						default: state_q <= S_IDLE;
					endcase
				end
				S_UL0: state_q <= S_UL1;
				S_UL1: begin
					unn_q   <= mem_rdata;
					state_q <= S_UL2;
				end
				S_UL2: begin
					unp_q   <= mem_rdata;
					state_q <= S_UL3;
				end
				S_UL3: begin
					if (unp_q == '0) head_q <= unn_q;
					state_q <= S_UL4;
				end
				S_UL4: state_q <= lret_q;
				S_PU0: state_q <= S_PU1;
				S_PU1: state_q <= S_PU2;
				S_PU2: begin
					head_q  <= ps_q;
					state_q <= lret_q;
				end
				S_PL0: state_q <= S_PL1;
				S_PL1: begin
					c_q     <= rd_sz;
					un_q    <= pl_q;
					lret_q  <= S_PL2;
					state_q <= S_UL0;
				end
				S_PL2: begin
					if (c_q >= asize_q && c_q - asize_q >= MIN_BLOCK) state_q <= S_PL3;
					else state_q <= S_PL7;
				end
				S_PL3: state_q <= S_PL4;
				S_PL4: state_q <= S_PL5;
				S_PL5: state_q <= S_PL6;
				S_PL6: begin
					ps_q    <= pl_q + asize_q;
					lret_q  <= S_ADONE;
					state_q <= S_PU0;
				end
				S_PL7: state_q <= S_PL8;
				S_PL8: state_q <= S_ADONE;
				S_ADONE: begin
					res_q <= pl_q[15:0];
					st_q  <= ST_OK;
					if (mv_q && pl_q != '0) begin
						copy_q  <= (bytes32 < old_cp) ? bytes_q : old_cp[16:0];
						moved_q <= 1'b1;
						state_q <= S_FR0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FR0: state_q <= S_FR1;
				S_FR1: begin
					s_q     <= rd_sz;
					state_q <= S_FR2;
				end
				S_FR2: state_q <= S_FR3;
				S_FR3: begin
					bp_q    <= ptr_q;
					mret_q  <= MR_FREE;
					state_q <= S_M0;
				end
				S_RS0: state_q <= S_RS1;
				S_RS1: begin
					old_q   <= rd_sz;
					asize_q <= (bytes32 + ALIGN_ADD) & SIZE_MASK;
					nx_q    <= ptr_q + rd_sz;
					state_q <= S_RS2;
				end
				S_RS2: state_q <= S_RS3;
				S_RS3: begin
					if (asize_q <= old_q) begin
						res_q   <= ptr_q[15:0];
						state_q <= S_DONE;
					end else if (!mem_rdata[0] && old_q + rd_sz >= asize_q) begin
						un_q    <= nx_q;
						lret_q  <= S_RS4;
						state_q <= S_UL0;
					end else begin
						mv_q    <= 1'b1;
						state_q <= S_ALLOC;
					end
				end
				S_RS4: state_q <= S_RS5;
				S_RS5: begin
					s_q     <= old_q + rd_sz;
					state_q <= S_RS6;
				end
				S_RS6: state_q <= S_RS7;
				S_RS7: begin
					res_q   <= ptr_q[15:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_taken) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
